### src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/cct_pkg.sv
package cct_pkg;

  // Default sizing
  localparam int MAX_ARGS_DEF = 4;
  localparam int LINE_MAX_DEF = 1024;

  // Token length saturates here
  localparam logic [9:0] LEN_CAP = 10'd1023;

  // Characters the parser reacts to
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Result kinds
  localparam logic [1:0] KIND_NAME  = 2'd0;
  localparam logic [1:0] KIND_ARG   = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  // Error codes
  localparam logic [1:0] ERR_NO_NAME       = 2'd0;
  localparam logic [1:0] ERR_UNCLOSED_CALL = 2'd1;
  localparam logic [1:0] ERR_UNCLOSED_CMD  = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] arg_index;
    logic [9:0] start_res;
    logic [9:0] length;
    logic [3:0] arg_count;
    logic [1:0] error_code;
    logic       last;
  } cct_result_t;

  // Up to two results produced by one byte
  typedef struct packed {
    logic [1:0]  count;
    cct_result_t first;
    cct_result_t second;
  } cct_batch_t;

endpackage

### src/cct_parser.sv
module cct_parser #(
  parameter int MAX_ARGS = 4,
  parameter int LINE_MAX = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic [7:0]        ch,
  output logic              item_stall,
  input  logic              take,
  output logic              fire,
  output cct_pkg::cct_batch_t batch
);
  import cct_pkg::*;

  localparam int POS_W = $clog2(LINE_MAX);

  localparam logic [2:0] PH_SKIP       = 3'd0;
  localparam logic [2:0] PH_NAME       = 3'd1;
  localparam logic [2:0] PH_ARG_SKIP   = 3'd2;
  localparam logic [2:0] PH_ARG_BODY   = 3'd3;
  localparam logic [2:0] PH_AFTER_MAX  = 3'd4;
  localparam logic [2:0] PH_CLOSE_WAIT = 3'd5;
  localparam logic [2:0] PH_DRAIN      = 3'd6;

  logic             byte_valid;
  logic [7:0]       byte_q;
  logic [2:0]       phase, phase_next;
  logic [POS_W-1:0] position, position_next;
  logic [POS_W-1:0] token_begin, token_begin_next;
  logic [9:0]       token_length, token_length_next;
  logic [3:0]       argument_number, argument_number_next;

  logic             blank;
  logic [9:0]       grown;
  logic [3:0]       arg_inc;
  logic [9:0]       pos10;
  logic [9:0]       begin10;
  cct_result_t      res0, res1;
  logic [1:0]       nres;

  function automatic cct_result_t mk(logic [1:0] kind, logic [2:0] idx,
                                     logic [9:0] start, logic [9:0] len,
                                     logic [3:0] cnt, logic [1:0] err);
    cct_result_t r;
    r.kind       = kind;
    r.arg_index  = idx;
    r.start_res  = start;
    r.length     = len;
    r.arg_count  = cnt;
    r.error_code = err;
    r.last       = 1'b0;
    return r;
  endfunction

  // Work on the held byte only when the output side can take its results
  assign fire       = byte_valid && take;
  assign item_stall = byte_valid && !take;

  assign blank   = (byte_q == CH_SPACE) || (byte_q == CH_TAB);
  assign grown   = (token_length < LEN_CAP) ? token_length + 10'd1 : LEN_CAP;
  assign arg_inc = argument_number + 4'd1;
  assign pos10   = 10'(position);
  assign begin10 = 10'(token_begin);

  // One parse step per byte
  always_comb begin
    phase_next           = phase;
    token_begin_next     = token_begin;
    token_length_next    = token_length;
    argument_number_next = argument_number;
    res0                 = '0;
    res1                 = '0;
    nres                 = 2'd0;

    case (phase)
      PH_SKIP: begin
        if (byte_q inside {CH_NUL, CH_LPAREN, CH_RBRACE}) begin
          res0       = mk(KIND_ERROR, 3'd0, 10'd0, 10'd0, 4'd0, ERR_NO_NAME);
          nres       = 2'd1;
          phase_next = PH_DRAIN;
        end else if (!(byte_q == CH_LBRACE || blank)) begin
          token_begin_next     = position;
          token_length_next    = 10'd1;
          argument_number_next = 4'd0;
          phase_next           = PH_NAME;
        end
      end
      PH_NAME: begin
        if (byte_q inside {CH_NUL, CH_LPAREN, CH_RBRACE}) begin
          res0                 = mk(KIND_NAME, 3'd0, begin10, token_length, 4'd0, 2'd0);
          argument_number_next = 4'd0;
          if (byte_q == CH_LPAREN) begin
            nres       = 2'd1;
            phase_next = PH_ARG_SKIP;
          end else if (byte_q == CH_RBRACE) begin
            res1       = mk(KIND_DONE, 3'd0, 10'd0, 10'd0, 4'd0, 2'd0);
            nres       = 2'd2;
            phase_next = PH_DRAIN;
          end else begin
            res1 = mk(KIND_ERROR, 3'd0, 10'd0, 10'd0, 4'd0, ERR_UNCLOSED_CMD);
            nres = 2'd2;
          end
        end else begin
          token_length_next = grown;
        end
      end
      PH_ARG_SKIP, PH_ARG_BODY: begin
        if (byte_q == CH_NUL) begin
          res0 = mk(KIND_ERROR, 3'd0, 10'd0, 10'd0, 4'd0, ERR_UNCLOSED_CALL);
          nres = 2'd1;
        end else if (byte_q inside {CH_COMMA, CH_RPAREN}) begin
          // An argument with no bytes starts at its terminator
          if (phase == PH_ARG_SKIP) begin
            token_begin_next  = position;
            token_length_next = 10'd0;
          end
          if (byte_q == CH_RPAREN && phase == PH_ARG_SKIP
              && argument_number == 4'd0) begin
            phase_next = PH_CLOSE_WAIT;
          end else begin
            res0 = mk(KIND_ARG, argument_number[2:0],
                      (phase == PH_ARG_SKIP) ? pos10 : begin10,
                      (phase == PH_ARG_SKIP) ? 10'd0 : token_length,
                      4'd0, 2'd0);
            nres                 = 2'd1;
            argument_number_next = arg_inc;
            if (byte_q == CH_RPAREN) begin
              phase_next = PH_CLOSE_WAIT;
            end else if (arg_inc >= 4'(MAX_ARGS)) begin
              phase_next = PH_AFTER_MAX;
            end else begin
              phase_next = PH_ARG_SKIP;
            end
          end
        end else if (phase == PH_ARG_SKIP) begin
          if (!blank) begin
            token_begin_next  = position;
            token_length_next = 10'd1;
            phase_next        = PH_ARG_BODY;
          end
        end else begin
          token_length_next = grown;
        end
      end
      PH_AFTER_MAX: begin
        if (byte_q == CH_RPAREN) begin
          phase_next = PH_CLOSE_WAIT;
        end else begin
          res0       = mk(KIND_ERROR, 3'd0, 10'd0, 10'd0, 4'd0, ERR_UNCLOSED_CALL);
          nres       = 2'd1;
          phase_next = PH_DRAIN;
        end
      end
      PH_CLOSE_WAIT: begin
        if (byte_q == CH_RBRACE) begin
          res0       = mk(KIND_DONE, 3'd0, 10'd0, 10'd0, argument_number, 2'd0);
          nres       = 2'd1;
          phase_next = PH_DRAIN;
        end else if (byte_q == CH_NUL) begin
          res0 = mk(KIND_ERROR, 3'd0, 10'd0, 10'd0, 4'd0, ERR_UNCLOSED_CMD);
          nres = 2'd1;
        end
      end
      default: begin
        phase_next = PH_DRAIN;
      end
    endcase

    // End of line restarts the parse
    if (byte_q == CH_NUL) begin
      phase_next    = PH_SKIP;
      position_next = '0;
    end else begin
      position_next = (position < POS_W'(LINE_MAX - 1)) ? position + POS_W'(1)
                                                         : position;
    end

    // Mark the final result of this byte
    res0.last = (nres == 2'd1);
    res1.last = 1'b1;
  end

  assign batch.count  = nres;
  assign batch.first  = res0;
  assign batch.second = res1;

  // Input register: load on transfer, drop once processed
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      byte_valid <= 1'b1;
    end else if (fire) begin
      byte_valid <= 1'b0;
    end
    if (item_valid && !item_stall) begin
      byte_q <= ch;
    end
  end

  // Parser state: advance on each processed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SKIP;
      position        <= '0;
      token_begin     <= '0;
      token_length    <= '0;
      argument_number <= '0;
    end else if (fire) begin
      phase           <= phase_next;
      position        <= position_next;
      token_begin     <= token_begin_next;
      token_length    <= token_length_next;
      argument_number <= argument_number_next;
    end
  end

endmodule

### src/command_call_tokenizer_unit.sv
// Command call tokenizer: takes one text byte per transfer on the item channel
// and emits name, argument, done and error results for commands written as
// {name(arg,...)}, a zero byte closing each line. A byte is held in the
// input register until the output buffer can take its results; they are then
// loaded into a two-entry output buffer that drives the result channel. The
// block takes one byte per cycle while results are taken as they appear; a
// byte that causes two results (a name closed by '}' or by a zero byte) holds
// the input while the first of the two leaves the output buffer.
module command_call_tokenizer_unit #(
  parameter int MAX_ARGS = cct_pkg::MAX_ARGS_DEF,
  parameter int LINE_MAX = cct_pkg::LINE_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [7:0] ch,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [1:0] kind,
  output logic [2:0] arg_index,
  output logic [9:0] start_res,
  output logic [9:0] length,
  output logic [3:0] arg_count,
  output logic [1:0] error_code,
  output logic       last
);
  import cct_pkg::*;

  logic        take;
  logic        fire;
  cct_batch_t  batch;
  cct_result_t slot0, slot1;
  logic [1:0]  occupancy;
  logic        pop;

  cct_parser #(
    .MAX_ARGS (MAX_ARGS),
    .LINE_MAX (LINE_MAX)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .ch         (ch),
    .item_stall (item_stall),
    .take       (take),
    .fire       (fire),
    .batch      (batch)
  );

  assign res_valid = (occupancy != 2'd0);
  assign pop       = res_valid && !res_stall;
  // Buffer is free for a new batch when it is empty or empties this cycle
  assign take      = (occupancy == 2'd0) || (occupancy == 2'd1 && pop);

  // Output buffer: load a batch, or shift forward on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= 2'd0;
    end else if (fire && batch.count != 2'd0) begin
      occupancy <= batch.count;
    end else if (pop) begin
      occupancy <= occupancy - 2'd1;
    end
    if (fire && batch.count != 2'd0) begin
      slot0 <= batch.first;
      slot1 <= batch.second;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

  assign kind       = slot0.kind;
  assign arg_index  = slot0.arg_index;
  assign start_res  = slot0.start_res;
  assign length     = slot0.length;
  assign arg_count  = slot0.arg_count;
  assign error_code = slot0.error_code;
  assign last       = slot0.last;

endmodule

### src/cct_checker.sv
`include "assert_macros.svh"

module cct_checker #(
  parameter int MAX_ARGS = 4
) (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_stall,
  input logic [1:0] kind,
  input logic [2:0] arg_index,
  input logic [9:0] start_res,
  input logic [9:0] length,
  input logic [3:0] arg_count,
  input logic [1:0] error_code,
  input logic       last
);
  import cct_pkg::*;

  // Held result keeps its payload
  `ASSERT_NXT(a_hold, clk, rst, res_valid && res_stall, res_valid && $stable({kind, arg_index, start_res, length, arg_count, error_code, last}), "stalled result changed")

  // Done and error always close a byte's results
  `ASSERT_IMP(a_close_last, clk, rst, res_valid && (kind == KIND_DONE || kind == KIND_ERROR), last && start_res == 10'd0 && length == 10'd0, "done or error malformed")

  // Argument tokens stay within the allowed count
  `ASSERT_IMP(a_arg_range, clk, rst, res_valid && kind == KIND_ARG, {1'b0, arg_index} < 4'(MAX_ARGS) && arg_count == 4'd0, "argument index out of range")

  // Done count never exceeds the limit
  `ASSERT_IMP(a_done_count, clk, rst, res_valid && kind == KIND_DONE, arg_count <= 4'(MAX_ARGS) && error_code == 2'd0, "done count out of range")

  // A second result follows a non-final one at once
  `ASSERT_NXT(a_follow, clk, rst, res_valid && !res_stall && !last, res_valid, "second result missing")

endmodule

bind command_call_tokenizer_unit cct_checker #(
  .MAX_ARGS (MAX_ARGS)
) u_cct_checker (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (res_valid),
  .res_stall  (res_stall),
  .kind       (kind),
  .arg_index  (arg_index),
  .start_res  (start_res),
  .length     (length),
  .arg_count  (arg_count),
  .error_code (error_code),
  .last       (last)
);
